FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on clk and are quiet while arst_n is low.
`define BUI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

`define BUI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

FILE: hw/rtl/bui_pkg.sv
package bui_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int UV_BITS_DEF = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	localparam int CFG_W = 32;
	localparam logic [CFG_W-1:0] MIN_DET_RESET = 32'd1;
	localparam int NUM_CORNERS = 3;
	localparam int MUL_CHUNK = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [4:0] STEP_FIRST = 5'd0;
	localparam logic [4:0] STEP_DET_LAST = 5'd20;
	localparam logic [4:0] STEP_UV_FIRST = 5'd21;
	localparam logic [4:0] STEP_LAST = 5'd26;

	typedef enum logic [3:0] {
		SEL_E0, SEL_E1, SEL_R, SEL_D00, SEL_D01, SEL_D11, SEL_R0, SEL_R1, SEL_W, SEL_UV
	} sel_t;

	typedef enum logic [3:0] {
		DST_D00, DST_D01, DST_D11, DST_R0, DST_R1, DST_DET, DST_NA, DST_NB, DST_SU, DST_SV
	} dst_t;

	typedef struct packed {
		sel_t a_sel;
		sel_t b_sel;
		logic [1:0] k;
		logic comp;
		dst_t dst;
		logic sub;
	} uop_t;

	typedef struct packed {
		logic load;
		logic query;
		logic mul_start;
		logic [4:0] step;
		logic wb;
		logic div_start;
		logic div_b;
		logic fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic degen;
		logic in_tri;
		logic out_full;
	} sts_t;

	function automatic uop_t mk(sel_t a, sel_t b, logic [1:0] k, logic c, dst_t d, logic s);
		uop_t u;
		u.a_sel = a;
		u.b_sel = b;
		u.k = k;
		u.comp = c;
		u.dst = d;
		u.sub = s;
		return u;
	endfunction

	function automatic uop_t uop_rom(logic [4:0] step);
		uop_t u;
		unique case (step)
			5'd0: u = mk(SEL_E0, SEL_E0, 2'd0, 1'b0, DST_D00, 1'b0);
			5'd1: u = mk(SEL_E0, SEL_E1, 2'd0, 1'b0, DST_D01, 1'b0);
			5'd2: u = mk(SEL_E1, SEL_E1, 2'd0, 1'b0, DST_D11, 1'b0);
			5'd3: u = mk(SEL_E0, SEL_R, 2'd0, 1'b0, DST_R0, 1'b0);
			5'd4: u = mk(SEL_E1, SEL_R, 2'd0, 1'b0, DST_R1, 1'b0);
			5'd5: u = mk(SEL_E0, SEL_E0, 2'd1, 1'b0, DST_D00, 1'b0);
			5'd6: u = mk(SEL_E0, SEL_E1, 2'd1, 1'b0, DST_D01, 1'b0);
			5'd7: u = mk(SEL_E1, SEL_E1, 2'd1, 1'b0, DST_D11, 1'b0);
			5'd8: u = mk(SEL_E0, SEL_R, 2'd1, 1'b0, DST_R0, 1'b0);
			5'd9: u = mk(SEL_E1, SEL_R, 2'd1, 1'b0, DST_R1, 1'b0);
			5'd10: u = mk(SEL_E0, SEL_E0, 2'd2, 1'b0, DST_D00, 1'b0);
			5'd11: u = mk(SEL_E0, SEL_E1, 2'd2, 1'b0, DST_D01, 1'b0);
			5'd12: u = mk(SEL_E1, SEL_E1, 2'd2, 1'b0, DST_D11, 1'b0);
			5'd13: u = mk(SEL_E0, SEL_R, 2'd2, 1'b0, DST_R0, 1'b0);
			5'd14: u = mk(SEL_E1, SEL_R, 2'd2, 1'b0, DST_R1, 1'b0);
			5'd15: u = mk(SEL_D00, SEL_D11, 2'd0, 1'b0, DST_DET, 1'b0);
			5'd16: u = mk(SEL_D01, SEL_D01, 2'd0, 1'b0, DST_DET, 1'b1);
			5'd17: u = mk(SEL_D11, SEL_R0, 2'd0, 1'b0, DST_NA, 1'b0);
			5'd18: u = mk(SEL_D01, SEL_R1, 2'd0, 1'b0, DST_NA, 1'b1);
			5'd19: u = mk(SEL_D00, SEL_R1, 2'd0, 1'b0, DST_NB, 1'b0);
			5'd20: u = mk(SEL_D01, SEL_R0, 2'd0, 1'b0, DST_NB, 1'b1);
			5'd21: u = mk(SEL_W, SEL_UV, 2'd0, 1'b0, DST_SU, 1'b0);
			5'd22: u = mk(SEL_W, SEL_UV, 2'd1, 1'b0, DST_SU, 1'b0);
			5'd23: u = mk(SEL_W, SEL_UV, 2'd2, 1'b0, DST_SU, 1'b0);
			5'd24: u = mk(SEL_W, SEL_UV, 2'd0, 1'b1, DST_SV, 1'b0);
			5'd25: u = mk(SEL_W, SEL_UV, 2'd1, 1'b1, DST_SV, 1'b0);
			5'd26: u = mk(SEL_W, SEL_UV, 2'd2, 1'b1, DST_SV, 1'b0);
			default: u = mk(SEL_E0, SEL_E0, 2'd0, 1'b0, DST_D00, 1'b0);
		endcase
		return u;
	endfunction

endpackage

FILE: hw/rtl/bui_ctrl.sv
module bui_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tuser,
	output logic s_tready,
	output bui_pkg::cmd_t cmd,
	input bui_pkg::sts_t st
);
	import bui_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_DIVA = 8'b0000_1000,
		ST_DIVB = 8'b0001_0000,
		ST_FIN = 8'b0010_0000,
		ST_TEST = 8'b0100_0000,
		ST_FINAL = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [4:0] step_q, step_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		step_d = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == CMD_QUERY) begin
						cmd.query = 1'b1;
						cmd.mul_start = 1'b1;
						cmd.step = STEP_FIRST;
						step_d = STEP_FIRST;
						state_d = ST_MUL;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_MUL: begin
				if (st.mul_done) begin
					cmd.wb = 1'b1;
					if (step_q == STEP_DET_LAST) begin
						state_d = ST_CHECK;
					end else if (step_q == STEP_LAST) begin
						state_d = ST_FINAL;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.step = step_q + 5'd1;
						step_d = step_q + 5'd1;
					end
				end
			end
			ST_CHECK: begin
				if (st.degen) begin
					state_d = ST_FINAL;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIVA;
				end
			end
			ST_DIVA: begin
				if (st.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_b = 1'b1;
					state_d = ST_DIVB;
				end
			end
			ST_DIVB: begin
				if (st.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				if (st.in_tri) begin
					cmd.mul_start = 1'b1;
					cmd.step = STEP_UV_FIRST;
					step_d = STEP_UV_FIRST;
					state_d = ST_MUL;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!st.out_full) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_FIRST;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

endmodule

FILE: hw/rtl/bui_dp.sv
module bui_dp #(
	parameter int COORD_BITS = bui_pkg::COORD_BITS_DEF,
	parameter int UV_BITS = bui_pkg::UV_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = bui_pkg::WEIGHT_FRAC_BITS_DEF,
	localparam int WB = WEIGHT_FRAC_BITS + 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bui_pkg::CFG_W-1:0] cfg_wdata,
	input bui_pkg::cmd_t cmd,
	output bui_pkg::sts_t st,
	input logic [1:0] corner_slot,
	input logic signed [COORD_BITS-1:0] pos_x,
	input logic signed [COORD_BITS-1:0] pos_y,
	input logic signed [COORD_BITS-1:0] pos_z,
	input logic signed [UV_BITS-1:0] tex_u,
	input logic signed [UV_BITS-1:0] tex_v,
	input logic m_tready,
	output logic m_tvalid,
	output logic inside_res,
	output logic degenerate,
	output logic signed [WB-1:0] weight_a,
	output logic signed [WB-1:0] weight_b,
	output logic signed [WB-1:0] weight_c,
	output logic signed [UV_BITS-1:0] out_u,
	output logic signed [UV_BITS-1:0] out_v
);
	import bui_pkg::*;

	localparam int F = WEIGHT_FRAC_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int DOTW = 2 * DW + 2;
	localparam int MW = (DOTW >= WB) ? ((DOTW >= UV_BITS) ? DOTW : UV_BITS)
		: ((WB >= UV_BITS) ? WB : UV_BITS);
	localparam int NCH = (MW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BW = NCH * MUL_CHUNK;
	localparam int CW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PW = 2 * MW;
	localparam int DVW = PW + WB;
	localparam int QW = WB - 1;
	localparam int DCW = $clog2(WB);
	localparam logic signed [WB-1:0] W_ONE = WB'(1 << F);
	localparam logic signed [WB-1:0] W_NEG_ONE = -W_ONE;
	localparam logic signed [WB-1:0] W_MAX = WB'((1 << (WB - 1)) - 1);
	localparam logic signed [WB-1:0] W_MIN = -W_MAX - WB'(1);
	localparam logic signed [PW-1:0] UV_HI = PW'((1 << (UV_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] UV_LO = -UV_HI - PW'(1);
	localparam logic signed [PW-1:0] HALF = PW'(1 << (F - 1));

	logic signed [COORD_BITS-1:0] cpos_q [NUM_CORNERS][3];
	logic signed [UV_BITS-1:0] cuv_q [NUM_CORNERS][2];
	logic signed [COORD_BITS-1:0] qpt_q [3];
	logic [CFG_W-1:0] min_det_q;

	logic signed [DW-1:0] e0 [3];
	logic signed [DW-1:0] e1 [3];
	logic signed [DW-1:0] rv [3];

	logic signed [DOTW-1:0] d00_q, d01_q, d11_q, r0_q, r1_q;
	logic signed [PW-1:0] det_q, na_q, nb_q, su_q, sv_q;
	logic signed [WB-1:0] wa_q, wb_q, wc_q;

	uop_t uop;
	logic signed [MW-1:0] mul_a_q;
	logic [BW-1:0] mul_b_q;
	logic signed [PW-1:0] acc_q;
	dst_t dst_q;
	logic sub_q;
	logic mbusy_q, mdone_q;
	logic [CW-1:0] mcnt_q;
	logic [MUL_CHUNK-1:0] chunk;
	logic signed [MUL_CHUNK:0] chunk_s;
	logic signed [MW+MUL_CHUNK:0] part;
	logic signed [PW-1:0] term;

	logic signed [PW-1:0] num;
	logic [PW-1:0] nmag;
	logic [DVW-1:0] rem_q, ds_q;
	logic [QW-1:0] quo_q;
	logic [DCW-1:0] dcnt_q;
	logic dbusy_q, ddone_q, dneg_q, dsat_q, dselb_q;
	logic ge;
	logic signed [WB-1:0] wres;
	logic signed [WB+1:0] wsum;
	logic signed [WB-1:0] wc_sat;

	logic degen_c, inside_c;
	logic signed [PW-1:0] su_r, sv_r;

	function automatic logic signed [MW-1:0] pick(sel_t s, logic [1:0] k, logic c);
		logic signed [MW-1:0] v;
		case (s)
			SEL_E0: v = MW'(e0[k]);
			SEL_E1: v = MW'(e1[k]);
			SEL_R: v = MW'(rv[k]);
			SEL_D00: v = MW'(d00_q);
			SEL_D01: v = MW'(d01_q);
			SEL_D11: v = MW'(d11_q);
			SEL_R0: v = MW'(r0_q);
			SEL_R1: v = MW'(r1_q);
			SEL_W: begin
				case (k)
					2'd0: v = MW'(wa_q);
					2'd1: v = MW'(wb_q);
					default: v = MW'(wc_q);
				endcase
			end
			SEL_UV: v = MW'(cuv_q[k][c]);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [UV_BITS-1:0] sat_uv(logic signed [PW-1:0] x);
		logic signed [UV_BITS-1:0] r;
		if (x > UV_HI) begin
			r = UV_HI[UV_BITS-1:0];
		end else if (x < UV_LO) begin
			r = UV_LO[UV_BITS-1:0];
		end else begin
			r = x[UV_BITS-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MIN_DET_RESET;
			for (int i = 0; i < NUM_CORNERS; i++) begin
				for (int j = 0; j < 3; j++) begin
					cpos_q[i][j] <= '0;
				end
				cuv_q[i][0] <= '0;
				cuv_q[i][1] <= '0;
			end
		end else begin
			if (cfg_we) begin
				min_det_q <= cfg_wdata;
			end
			if (cmd.load && corner_slot < 2'(NUM_CORNERS)) begin
				cpos_q[corner_slot][0] <= pos_x;
				cpos_q[corner_slot][1] <= pos_y;
				cpos_q[corner_slot][2] <= pos_z;
				cuv_q[corner_slot][0] <= tex_u;
				cuv_q[corner_slot][1] <= tex_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			qpt_q[0] <= pos_x;
			qpt_q[1] <= pos_y;
			qpt_q[2] <= pos_z;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			e0[j] = DW'(cpos_q[0][j]) - DW'(cpos_q[2][j]);
			e1[j] = DW'(cpos_q[1][j]) - DW'(cpos_q[2][j]);
			rv[j] = DW'(qpt_q[j]) - DW'(cpos_q[2][j]);
		end
	end

	assign uop = uop_rom(cmd.step);

	// Multiplier walks operand b one chunk per cycle, top chunk first and signed.
	assign chunk = mul_b_q[BW-1 -: MUL_CHUNK];
	assign chunk_s = {(mcnt_q == '0) ? chunk[MUL_CHUNK-1] : 1'b0, chunk};
	assign part = mul_a_q * chunk_s;
	assign term = sub_q ? -acc_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				mcnt_q <= '0;
			end else if (mbusy_q) begin
				if (mcnt_q == CW'(NCH - 1)) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end else begin
					mcnt_q <= mcnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mul_a_q <= pick(uop.a_sel, uop.k, uop.comp);
			mul_b_q <= BW'(pick(uop.b_sel, uop.k, uop.comp));
			dst_q <= uop.dst;
			sub_q <= uop.sub;
			acc_q <= '0;
		end else if (mbusy_q) begin
			acc_q <= (acc_q <<< MUL_CHUNK) + PW'(part);
			mul_b_q <= mul_b_q << MUL_CHUNK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query) begin
			d00_q <= '0;
			d01_q <= '0;
			d11_q <= '0;
			r0_q <= '0;
			r1_q <= '0;
			det_q <= '0;
			na_q <= '0;
			nb_q <= '0;
			su_q <= '0;
			sv_q <= '0;
		end else if (cmd.wb) begin
			unique case (dst_q)
				DST_D00: d00_q <= d00_q + term[DOTW-1:0];
				DST_D01: d01_q <= d01_q + term[DOTW-1:0];
				DST_D11: d11_q <= d11_q + term[DOTW-1:0];
				DST_R0: r0_q <= r0_q + term[DOTW-1:0];
				DST_R1: r1_q <= r1_q + term[DOTW-1:0];
				DST_DET: det_q <= det_q + term;
				DST_NA: na_q <= na_q + term;
				DST_NB: nb_q <= nb_q + term;
				DST_SU: su_q <= su_q + term;
				DST_SV: sv_q <= sv_q + term;
				default: ;
			endcase
		end
	end

	// Restoring divider, one quotient bit per cycle after an overflow check.
	assign num = cmd.div_b ? nb_q : na_q;
	assign nmag = num[PW-1] ? PW'(-num) : PW'(num);
	assign ge = (rem_q >= ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q <= DCW'(QW);
			end else if (dbusy_q) begin
				if ((dcnt_q == DCW'(QW) && ge) || dcnt_q == '0) begin
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end else begin
					dcnt_q <= dcnt_q - DCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= DVW'(nmag) << F;
			ds_q <= DVW'($unsigned(det_q)) << QW;
			quo_q <= '0;
			dneg_q <= num[PW-1];
			dsat_q <= 1'b0;
			dselb_q <= cmd.div_b;
		end else if (dbusy_q) begin
			if (dcnt_q == DCW'(QW)) begin
				if (ge) begin
					dsat_q <= 1'b1;
				end
			end else begin
				if (ge) begin
					rem_q <= rem_q - ds_q;
				end
				quo_q <= {quo_q[QW-2:0], ge};
			end
			ds_q <= ds_q >> 1;
		end
	end

	always_comb begin
		if (dsat_q) begin
			wres = dneg_q ? W_MIN : W_MAX;
		end else begin
			wres = dneg_q ? -$signed(WB'(quo_q)) : $signed(WB'(quo_q));
		end
		wsum = (WB+2)'(W_ONE) - (WB+2)'(wa_q) - (WB+2)'(wb_q);
		if (wsum > (WB+2)'(W_MAX)) begin
			wc_sat = W_MAX;
		end else if (wsum < (WB+2)'(W_MIN)) begin
			wc_sat = W_MIN;
		end else begin
			wc_sat = wsum[WB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ddone_q) begin
			if (dselb_q) begin
				wb_q <= wres;
			end else begin
				wa_q <= wres;
			end
		end
		if (cmd.fin) begin
			wc_q <= wc_sat;
		end
	end

	assign degen_c = det_q[PW-1] || (det_q == '0) || ($unsigned(det_q) < PW'(min_det_q));
	assign inside_c = !wa_q[WB-1] && (wa_q <= W_ONE) && !wb_q[WB-1] && (wb_q <= W_ONE)
		&& !wc_q[WB-1] && (wc_q <= W_ONE);
	assign su_r = (su_q + HALF) >>> F;
	assign sv_r = (sv_q + HALF) >>> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (degen_c) begin
				inside_res <= 1'b0;
				degenerate <= 1'b1;
				weight_a <= W_NEG_ONE;
				weight_b <= W_NEG_ONE;
				weight_c <= W_NEG_ONE;
				out_u <= '0;
				out_v <= '0;
			end else begin
				inside_res <= inside_c;
				degenerate <= 1'b0;
				weight_a <= wa_q;
				weight_b <= wb_q;
				weight_c <= wc_q;
				out_u <= inside_c ? sat_uv(su_r) : '0;
				out_v <= inside_c ? sat_uv(sv_r) : '0;
			end
		end
	end

	assign st.mul_done = mdone_q;
	assign st.div_done = ddone_q;
	assign st.degen = degen_c;
	assign st.in_tri = inside_c;
	assign st.out_full = m_tvalid && !m_tready;

endmodule

FILE: hw/rtl/barycentric_uv_interpolator_top.sv
// A load request is taken without leaving the idle state and gives no result.
// A query runs 21 multiplies on one shared chunked multiplier that walks operand b in NCH
// chunks, NCH = ceil(max(2*COORD_BITS + 4, WEIGHT_FRAC_BITS + 2, UV_BITS) / 16); when not
// degenerate it adds two divides, and six more multiplies when the point is inside.
// One query is in flight at a time.
// Reset clears the corner store to zero and sets min_determinant to 1.
module barycentric_uv_interpolator_top #(
	parameter int COORD_BITS = bui_pkg::COORD_BITS_DEF,
	parameter int UV_BITS = bui_pkg::UV_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = bui_pkg::WEIGHT_FRAC_BITS_DEF,
	localparam int WB = WEIGHT_FRAC_BITS + 2,
	localparam int S_DW = ((2 + 3 * COORD_BITS + 2 * UV_BITS + 7) / 8) * 8,
	localparam int M_DW = ((3 * WB + 2 * UV_BITS + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bui_pkg::CFG_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	// corner_slot, pos_x, pos_y, pos_z, tex_u, tex_v
	input logic [S_DW-1:0] s_tdata,
	// command
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// weight_a, weight_b, weight_c, out_u, out_v
	output logic [M_DW-1:0] m_tdata,
	// inside_res, degenerate
	output logic [1:0] m_tuser
);
	import bui_pkg::*;

	localparam int PX = 2;
	localparam int PY = PX + COORD_BITS;
	localparam int PZ = PY + COORD_BITS;
	localparam int TU = PZ + COORD_BITS;
	localparam int TV = TU + UV_BITS;
	localparam int S_USED = TV + UV_BITS;
	localparam int M_USED = 3 * WB + 2 * UV_BITS;

	cmd_t cmd;
	sts_t st;
	logic inside_res, degenerate;
	logic signed [WB-1:0] weight_a, weight_b, weight_c;
	logic signed [UV_BITS-1:0] out_u, out_v;

	bui_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser(s_tuser),
		.s_tready(s_tready),
		.cmd(cmd),
		.st(st)
	);

	bui_dp #(
		.COORD_BITS(COORD_BITS),
		.UV_BITS(UV_BITS),
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.st(st),
		.corner_slot(s_tdata[1:0]),
		.pos_x(s_tdata[PX +: COORD_BITS]),
		.pos_y(s_tdata[PY +: COORD_BITS]),
		.pos_z(s_tdata[PZ +: COORD_BITS]),
		.tex_u(s_tdata[TU +: UV_BITS]),
		.tex_v(s_tdata[TV +: UV_BITS]),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.inside_res(inside_res),
		.degenerate(degenerate),
		.weight_a(weight_a),
		.weight_b(weight_b),
		.weight_c(weight_c),
		.out_u(out_u),
		.out_v(out_v)
	);

	assign m_tuser = {degenerate, inside_res};
	assign m_tdata = M_DW'({out_v, out_u, weight_c, weight_b, weight_a});

	`include "assert_macros.svh"

	`BUI_ASSERT_IMP(a_degen_not_inside, m_tvalid && m_tuser[1], !m_tuser[0])
	`BUI_ASSERT_IMP(a_one_unit_done, st.mul_done, !st.div_done)
	`BUI_ASSERT_NXT(a_query_blocks, s_tvalid && s_tready && s_tuser == CMD_QUERY, !s_tready)
	`BUI_ASSERT_IMP(a_load_has_room, cmd.out_load, !st.out_full && S_USED <= S_DW && M_USED <= M_DW)

endmodule

FILE: sim/tb_barycentric_uv_interpolator_top.sv
`timescale 1ns / 100ps

module tb_barycentric_uv_interpolator_top;
	import bui_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int UVB = UV_BITS_DEF;
	localparam int WF = WEIGHT_FRAC_BITS_DEF;
	localparam int WB = WF + 2;
	localparam int S_DW = ((2 + 3 * CB + 2 * UVB + 7) / 8) * 8;
	localparam int M_DW = ((3 * WB + 2 * UVB + 7) / 8) * 8;
	localparam longint ONE = 64'sd1 <<< WF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int ITEMS_PER_PHASE = 340;
	localparam int NUM_PHASES = 5;

	typedef logic signed [191:0] wide_t;

	typedef struct {
		logic in_tri;
		logic degen;
		logic [WB-1:0] wa;
		logic [WB-1:0] wb;
		logic [WB-1:0] wc;
		logic [UVB-1:0] u;
		logic [UVB-1:0] v;
	} uv_result_t;

	typedef struct {
		logic cmd;
		logic [1:0] slot;
		int x;
		int y;
		int z;
		int u;
		int v;
		bit typed;
	} request_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [S_DW-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DW-1:0] m_tdata;
	logic [1:0] m_tuser;

	logic signed [CB-1:0] corner_pos [3][3];
	logic signed [UVB-1:0] corner_uv [3][2];
	logic [CFG_W-1:0] det_threshold;
	uv_result_t pending_uv[$];
	int mismatches;
	int cycles;
	int requests_sent;
	bit calm;

	barycentric_uv_interpolator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic longint clamp(longint x, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
	endfunction

	function automatic longint weight_quotient(wide_t num, wide_t det);
		logic [191:0] mag;
		logic [191:0] q;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (mag << WF) / $unsigned(det);
		if (q >= (192'd1 << (WB - 1)))
			return neg ? -(64'sd1 <<< (WB - 1)) : (64'sd1 <<< (WB - 1)) - 1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint blend_uv(longint wt [3], int comp);
		longint s;
		s = 0;
		for (int k = 0; k < 3; k++)
			s += wt[k] * longint'(corner_uv[k][comp]);
		s += 64'sd1 <<< (WF - 1);
		return clamp(s >>> WF, UVB);
	endfunction

	function automatic uv_result_t interpolate_point(logic signed [CB-1:0] qp [3]);
		wide_t e0, e1, rq, d00, d01, d11, r0, r1, det;
		longint wt [3];
		uv_result_t r;
		d00 = 0;
		d01 = 0;
		d11 = 0;
		r0 = 0;
		r1 = 0;
		for (int k = 0; k < 3; k++) begin
			e0 = wide_t'(corner_pos[0][k]) - wide_t'(corner_pos[2][k]);
			e1 = wide_t'(corner_pos[1][k]) - wide_t'(corner_pos[2][k]);
			rq = wide_t'(qp[k]) - wide_t'(corner_pos[2][k]);
			d00 += e0 * e0;
			d01 += e0 * e1;
			d11 += e1 * e1;
			r0 += e0 * rq;
			r1 += e1 * rq;
		end
		det = d00 * d11 - d01 * d01;
		r.in_tri = 1'b0;
		r.u = '0;
		r.v = '0;
		r.degen = (det <= 0) || (det < wide_t'({1'b0, det_threshold}));
		if (r.degen) begin
			wt[0] = -ONE;
			wt[1] = -ONE;
			wt[2] = -ONE;
		end else begin
			wt[0] = weight_quotient(d11 * r0 - d01 * r1, det);
			wt[1] = weight_quotient(d00 * r1 - d01 * r0, det);
			wt[2] = clamp(ONE - wt[0] - wt[1], WB);
			r.in_tri = 1'b1;
			for (int k = 0; k < 3; k++)
				if (wt[k] < 0 || wt[k] > ONE)
					r.in_tri = 1'b0;
			if (r.in_tri) begin
				r.u = UVB'(blend_uv(wt, 0));
				r.v = UVB'(blend_uv(wt, 1));
			end
		end
		r.wa = WB'(wt[0]);
		r.wb = WB'(wt[1]);
		r.wc = WB'(wt[2]);
		return r;
	endfunction

	function automatic uv_result_t degenerate_result();
		uv_result_t r;
		r.in_tri = 1'b0;
		r.degen = 1'b1;
		r.wa = WB'(-ONE);
		r.wb = WB'(-ONE);
		r.wc = WB'(-ONE);
		r.u = '0;
		r.v = '0;
		return r;
	endfunction

	function automatic int pick_gap();
		if (calm)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	task automatic send_request(logic cmd, logic [1:0] slot, int x, int y, int z, int u, int v,
			bit typed = 0);
		logic signed [CB-1:0] qp [3];
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= cmd;
		s_tdata <= {6'b0, UVB'(v), UVB'(u), CB'(z), CB'(y), CB'(x), slot};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		qp[0] = CB'(x);
		qp[1] = CB'(y);
		qp[2] = CB'(z);
		if (cmd == CMD_LOAD) begin
			if (slot < NUM_CORNERS) begin
				corner_pos[slot] = qp;
				corner_uv[slot][0] = UVB'(u);
				corner_uv[slot][1] = UVB'(v);
			end
		end else if (typed) begin
			pending_uv.push_back(degenerate_result());
		end else begin
			pending_uv.push_back(interpolate_point(qp));
		end
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_configure(logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		wait (pending_uv.size() == 0);
		repeat (20) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		det_threshold = value;
	endtask

	function automatic int rand_coord(int span);
		if (span == 0)
			return int'($signed(CB'($urandom)));
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic random_triangle_batch();
		int span, p [3][3], order [3], q [3], a, b, nq;
		span = ($urandom_range(0, 5) == 0) ? 0 : (1 << $urandom_range(4, 18));
		for (int c = 0; c < 3; c++)
			for (int k = 0; k < 3; k++)
				p[c][k] = rand_coord(span);
		case ($urandom_range(0, 9))
			0: p[1] = p[0];
			1: for (int k = 0; k < 3; k++) p[1][k] = 2 * p[0][k] - p[2][k];
			default: ;
		endcase
		order = '{0, 1, 2};
		order.shuffle();
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_request(CMD_LOAD, 2'd3, rand_coord(0), rand_coord(0), rand_coord(0),
					$urandom, $urandom);
			if ($urandom_range(0, 15) != 0)
				send_request(CMD_LOAD, 2'(order[i]), p[order[i]][0], p[order[i]][1],
					p[order[i]][2], $urandom, $urandom);
		end
		nq = $urandom_range(1, 8);
		for (int i = 0; i < nq; i++) begin
			case ($urandom_range(0, 7))
				0: for (int k = 0; k < 3; k++) q[k] = rand_coord(0);
				1: q = p[$urandom_range(0, 2)];
				default: begin
					a = $urandom_range(0, 384) - 64;
					b = $urandom_range(0, 384) - 64;
					if ($urandom_range(0, 1))
						b = $urandom_range(0, 256 - ((a < 0) ? 0 : (a > 256 ? 256 : a)));
					for (int k = 0; k < 3; k++)
						q[k] = int'(clamp(longint'(p[2][k])
							+ (longint'(a) * (p[0][k] - p[2][k])
							+ longint'(b) * (p[1][k] - p[2][k])) / 256
							+ $urandom_range(0, 2) - 1, CB));
				end
			endcase
			send_request(CMD_QUERY, 2'($urandom), q[0], q[1], q[2], $urandom, $urandom);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			int stall;
			@(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_uv.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				uv_result_t e;
				e = pending_uv.pop_front();
				if (m_tuser[0] !== e.in_tri) begin
					$error("inside_res expected %0d got %0d", e.in_tri, m_tuser[0]);
					mismatches++;
				end
				if (m_tuser[1] !== e.degen) begin
					$error("degenerate expected %0d got %0d", e.degen, m_tuser[1]);
					mismatches++;
				end
				if (m_tdata[WB-1:0] !== e.wa) begin
					$error("weight_a expected %h got %h", e.wa, m_tdata[WB-1:0]);
					mismatches++;
				end
				if (m_tdata[2*WB-1:WB] !== e.wb) begin
					$error("weight_b expected %h got %h", e.wb, m_tdata[2*WB-1:WB]);
					mismatches++;
				end
				if (m_tdata[3*WB-1:2*WB] !== e.wc) begin
					$error("weight_c expected %h got %h", e.wc, m_tdata[3*WB-1:2*WB]);
					mismatches++;
				end
				if (m_tdata[3*WB+UVB-1:3*WB] !== e.u) begin
					$error("out_u expected %h got %h", e.u, m_tdata[3*WB+UVB-1:3*WB]);
					mismatches++;
				end
				if (m_tdata[3*WB+2*UVB-1:3*WB+UVB] !== e.v) begin
					$error("out_v expected %h got %h", e.v, m_tdata[3*WB+2*UVB-1:3*WB+UVB]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		request_row_t directed [$];
		logic [CFG_W-1:0] thresholds [NUM_PHASES];
		int mx, mn;
		mx = (1 << (CB - 1)) - 1;
		mn = -(1 << (CB - 1));
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		mismatches = 0;
		cycles = 0;
		requests_sent = 0;
		calm = 0;
		det_threshold = MIN_DET_RESET;
		for (int c = 0; c < 3; c++) begin
			corner_pos[c] = '{default: '0};
			corner_uv[c] = '{default: '0};
		end
		directed = '{
			'{CMD_QUERY, 2'd0, 5, -7, 9, 0, 0, 1},
			'{CMD_LOAD, 2'd3, mx, mn, mx, 32767, -32768, 0},
			'{CMD_QUERY, 2'd3, mx, mn, mx, 0, 0, 1},
			'{CMD_LOAD, 2'd0, 256, 0, 0, 4096, 0, 0},
			'{CMD_LOAD, 2'd1, 512, 0, 0, 0, 4096, 0},
			'{CMD_QUERY, 2'd0, 100, 0, 0, 0, 0, 1},
			'{CMD_LOAD, 2'd1, 0, 256, 0, 0, 4096, 0},
			'{CMD_QUERY, 2'd1, 256, 0, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd2, 0, 256, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd0, 85, 85, 40, 0, 0, 0},
			'{CMD_QUERY, 2'd0, 300, 300, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd0, -10, 50, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd0, mx, mx, mx, 0, 0, 0},
			'{CMD_QUERY, 2'd0, mn, mn, mn, 0, 0, 0},
			'{CMD_LOAD, 2'd0, mx, mx, mx, 32767, 32767, 0},
			'{CMD_LOAD, 2'd1, mn, mx, mn, -32768, -32768, 0},
			'{CMD_LOAD, 2'd2, mn, mn, mx, 32767, -32768, 0},
			'{CMD_QUERY, 2'd0, 0, 0, 0, 0, 0, 0},
			'{CMD_QUERY, 2'd0, mx, mx, mx, 0, 0, 0},
			'{CMD_QUERY, 2'd0, mn, mn, mn, 0, 0, 0}
		};
		thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, 32'd256};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send_request(directed[i].cmd, directed[i].slot, directed[i].x, directed[i].y,
				directed[i].z, directed[i].u, directed[i].v, directed[i].typed);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_and_configure(thresholds[ph]);
			while (requests_sent < 21 + (ph + 1) * ITEMS_PER_PHASE) begin
				calm = ($urandom_range(0, 4) == 0);
				random_triangle_batch();
			end
		end
		calm = 0;
		s_tvalid <= 1'b0;
		wait (pending_uv.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
